[src/integer_pixel_replication_upscaler_unit_macros.svh]
// Assertion macros used by the upscaler RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_UNIT_MACROS_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPRU_ASSERT_IMPLIES(label, cond, expect_true) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_true)) \
    else $error("upscaler check failed");

// Next-cycle implication, checked outside reset.
`define IPRU_ASSERT_NEXT(label, cond, expect_true) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_true)) \
    else $error("upscaler check failed");

`endif

[src/ipru_pkg.sv]
`default_nettype none

package ipru_pkg;

  // Default depth of the line buffer in pixels.
  localparam int MAX_WIDTH_DEF = 2048;

  // Field and register widths.
  localparam int PIXEL_W    = 24;
  localparam int SCALE_W    = 7;
  localparam int SWIDTH_W   = 12;
  localparam int SHEIGHT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Limits of the enlargement factor.
  localparam logic [SCALE_W-1:0] SCALE_MIN = 7'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_PAD     = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

  typedef struct packed {
    opcode_t              opcode;
    logic [PIXEL_W-1:0]   pixel_in;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [PIXEL_W-1:0]   pixel_out;
    logic                 row_end;
    logic                 image_end;
  } result_t;

  // Line buffer command.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

endpackage

`default_nettype wire

[src/ipru_line_buf.sv]
`default_nettype none

module ipru_line_buf
  import ipru_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire mem_cmd_t           cmd,
  input  wire logic [AW-1:0]      addr,
  input  wire logic [PIXEL_W-1:0] wdata,
  output logic [PIXEL_W-1:0]      rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  // Single port: a write or a registered read each cycle. The read data
  // holds until the next read so a stalled result keeps its pixel.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[src/integer_pixel_replication_upscaler_unit.sv]
// Integer pixel-replication upscaler.
// Item channel (item_valid, item_stall, item): a push stores one source pixel
// into the line buffer, an advance emits the next output unit once a source
// row is complete. Every accepted item gives exactly one result on the result
// channel (result_valid, result_stall, result): nothing, a pixel, a zero
// padding byte or a refused push, with row and image end flags.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// scale, source width and source height; cfg_ready is always high and writes
// are expected only while the block is idle.
// A result passes the first stage, which holds its control while the
// registered read of the single-ported line buffer completes, and then the
// output register, which captures the read data.
// Throughput: one item per cycle while item_stall is low; the line buffer
// serves one write or one read per cycle and each item needs at most one.
// When the receiver stalls, the output register and one stage behind it fill,
// after which item_stall rises; the held result does not change.
// Reset clears all counters and sets the three registers to one. The line
// buffer is not cleared; every entry is written by a push before it is read.
`default_nettype none
`include "integer_pixel_replication_upscaler_unit_macros.svh"

module integer_pixel_replication_upscaler_unit
  import ipru_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > SWIDTH_W) ? CW : SWIDTH_W;

  // Configuration registers.
  logic [SCALE_W-1:0]   scale;
  logic [SWIDTH_W-1:0]  source_width;
  logic [SHEIGHT_W-1:0] source_height;

  // Row state.
  logic [CW-1:0]        fill_count, fill_count_next;
  logic                 row_ready, row_ready_next;
  logic [CW-1:0]        source_column, source_column_next;
  logic [SCALE_W-1:0]   horizontal_repeat, horizontal_repeat_next;
  logic [1:0]           padding_left, padding_left_next;
  logic [SCALE_W-1:0]   vertical_repeat, vertical_repeat_next;
  logic [SHEIGHT_W-1:0] row_count, row_count_next;
  logic                 in_padding, in_padding_next;

  // Effective register values and helpers.
  logic [SCALE_W-1:0]   scale_eff;
  logic [EW-1:0]        width_eff;
  logic [SHEIGHT_W-1:0] height_eff;
  logic                 full;
  logic [1:0]           pad_bytes;
  logic [SCALE_W:0]     hrep_inc;
  logic [SCALE_W:0]     vrep_inc;
  logic [SHEIGHT_W:0]   row_inc;
  logic                 end_row;

  // Pipeline.
  logic                 accept;
  logic                 s1_valid;
  logic                 s1_move;
  kind_t                s1_kind;
  logic                 s1_row_end;
  logic                 s1_image_end;
  kind_t                kind_now;
  logic                 row_end_now;
  logic                 image_end_now;

  // Line buffer port.
  mem_cmd_t             mem_cmd;
  logic [AW-1:0]        mem_addr;
  logic [PIXEL_W-1:0]   mem_rdata;

  ipru_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (item.pixel_in),
    .rdata (mem_rdata)
  );

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= SCALE_W'(1);
      source_width  <= SWIDTH_W'(1);
      source_height <= SHEIGHT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE:         scale         <= cfg_data[SCALE_W-1:0];
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SWIDTH_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values into their legal ranges.
  always_comb begin
    if (scale < SCALE_MIN) begin
      scale_eff = SCALE_MIN;
    end else if (scale > SCALE_MAX) begin
      scale_eff = SCALE_MAX;
    end else begin
      scale_eff = scale;
    end
    if (source_width == '0) begin
      width_eff = EW'(1);
    end else if (EW'(source_width) > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(source_width);
    end
    height_eff = (source_height == '0) ? SHEIGHT_W'(1) : source_height;
  end

  assign full      = row_ready || (EW'(fill_count) >= width_eff);
  // Output row padding is (width * scale) mod 4 bytes.
  assign pad_bytes = 2'(width_eff[1:0] * scale_eff[1:0]);
  assign hrep_inc  = {1'b0, horizontal_repeat} + 1'b1;
  assign vrep_inc  = {1'b0, vertical_repeat} + 1'b1;
  assign row_inc   = {1'b0, row_count} + 1'b1;

  // Handshake: the first stage moves on when the output register is free
  // or is handing its result over in this cycle.
  assign s1_move    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_move;
  assign accept     = item_valid && !item_stall;

  // Next row state and result control for the item in transfer.
  always_comb begin
    fill_count_next        = fill_count;
    row_ready_next         = row_ready;
    source_column_next     = source_column;
    horizontal_repeat_next = horizontal_repeat;
    padding_left_next      = padding_left;
    vertical_repeat_next   = vertical_repeat;
    row_count_next         = row_count;
    in_padding_next        = in_padding;
    kind_now               = KIND_NONE;
    row_end_now            = 1'b0;
    image_end_now          = 1'b0;
    end_row                = 1'b0;
    mem_cmd                = '0;
    mem_addr               = fill_count[AW-1:0];

    if (accept) begin
      if (item.opcode == OP_PUSH) begin
        if (full) begin
          kind_now = KIND_REFUSED;
        end else begin
          mem_cmd.wr      = 1'b1;
          fill_count_next = fill_count + 1'b1;
          if (EW'(fill_count_next) >= width_eff) begin
            row_ready_next = 1'b1;
          end
        end
      end else if (full) begin
        row_ready_next = 1'b1;
        if (!in_padding) begin
          // Replicated pixel: read the current source column.
          kind_now   = KIND_PIXEL;
          mem_cmd.rd = 1'b1;
          mem_addr   = source_column[AW-1:0];
          if (hrep_inc >= {1'b0, scale_eff}) begin
            horizontal_repeat_next = '0;
            source_column_next     = source_column + 1'b1;
            if (EW'(source_column_next) >= width_eff) begin
              if (pad_bytes != 2'd0) begin
                in_padding_next   = 1'b1;
                padding_left_next = pad_bytes;
              end else begin
                end_row = 1'b1;
              end
            end
          end else begin
            horizontal_repeat_next = hrep_inc[SCALE_W-1:0];
          end
        end else begin
          // Zero padding byte.
          kind_now = KIND_PAD;
          if (padding_left != 2'd0) begin
            padding_left_next = padding_left - 1'b1;
          end
          if (padding_left_next == 2'd0) begin
            end_row = 1'b1;
          end
        end

        // End of an output row: replay the line or free the buffer.
        if (end_row) begin
          row_end_now            = 1'b1;
          source_column_next     = '0;
          horizontal_repeat_next = '0;
          in_padding_next        = 1'b0;
          padding_left_next      = '0;
          if (vrep_inc >= {1'b0, scale_eff}) begin
            vertical_repeat_next = '0;
            fill_count_next      = '0;
            row_ready_next       = 1'b0;
            if (row_inc >= {1'b0, height_eff}) begin
              row_count_next = '0;
              image_end_now  = 1'b1;
            end else begin
              row_count_next = row_inc[SHEIGHT_W-1:0];
            end
          end else begin
            vertical_repeat_next = vrep_inc[SCALE_W-1:0];
          end
        end
      end
    end
  end

  // Row state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count        <= '0;
      row_ready         <= 1'b0;
      source_column     <= '0;
      horizontal_repeat <= '0;
      padding_left      <= '0;
      vertical_repeat   <= '0;
      row_count         <= '0;
      in_padding        <= 1'b0;
    end else begin
      fill_count        <= fill_count_next;
      row_ready         <= row_ready_next;
      source_column     <= source_column_next;
      horizontal_repeat <= horizontal_repeat_next;
      padding_left      <= padding_left_next;
      vertical_repeat   <= vertical_repeat_next;
      row_count         <= row_count_next;
      in_padding        <= in_padding_next;
    end
  end

  // First stage: result control waits here for the line buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= kind_now;
      s1_row_end   <= row_end_now;
      s1_image_end <= image_end_now;
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.kind      <= s1_kind;
      result.pixel_out <= (s1_kind == KIND_PIXEL) ? mem_rdata : '0;
      result.row_end   <= s1_row_end;
      result.image_end <= s1_image_end;
    end
  end

  // Checks on the row state and the result stage.
  `IPRU_ASSERT_IMPLIES(a_padding_has_bytes, in_padding, padding_left != 2'd0)
  `IPRU_ASSERT_IMPLIES(a_fill_in_range, 1'b1, fill_count <= CW'(MAX_WIDTH))
  `IPRU_ASSERT_IMPLIES(a_image_end_is_row_end, result_valid && result.image_end, result.row_end)
  `IPRU_ASSERT_IMPLIES(a_nonpixel_is_zero, result_valid && (result.kind != KIND_PIXEL), result.pixel_out == '0)
  `IPRU_ASSERT_NEXT(a_read_meets_pixel, accept && mem_cmd.rd, s1_valid && (s1_kind == KIND_PIXEL))

endmodule

`default_nettype wire
